// ===== src/pgpm_pkg.sv =====
// Package for the PWM gas sensor ppm meter: sizes, operation codes,
// register indexes and the configuration struct.
// No dependencies.
package pgpm_pkg;

  // Width of the window tick and high-sample counters
  localparam int COUNT_BITS = 11;
  localparam int TICK_W     = COUNT_BITS + 1;
  localparam int PROD_W     = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam int PPM_W   = 16;
  localparam int FAULT_W = 8;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_WINDOW_LAST   = 3'd0;
  localparam logic [IDX_W-1:0] REG_COUNT_OFFSET  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PPM_PER_COUNT = 3'd2;
  localparam logic [IDX_W-1:0] REG_PPM_FLOOR     = 3'd3;
  localparam logic [IDX_W-1:0] REG_FAULT_STOP    = 3'd4;
  localparam logic [IDX_W-1:0] REG_FAULT_RESTART = 3'd5;

  typedef struct packed {
    logic [10:0]        window_last_tick;
    logic [7:0]         count_offset;
    logic [3:0]         ppm_per_count;
    logic [PPM_W-1:0]   ppm_floor;
    logic [FAULT_W-1:0] fault_stop_count;
    logic [FAULT_W-1:0] fault_restart_count;
  } cfg_t;

endpackage

// ===== src/pgpm_in_if.sv =====
// Input channel: one operation beat with its sampled pin level.
// Depends on pgpm_pkg.
interface pgpm_in_if;
  logic          valid;
  logic          ready;
  pgpm_pkg::op_t operation;
  logic          pin_level;

  modport source (output valid, output operation, output pin_level, input ready);
  modport sink   (input valid, input operation, input pin_level, output ready);
endinterface

// ===== src/pgpm_out_if.sv =====
// Result channel: ppm reading, sensor supply and fault run after each beat.
// Depends on pgpm_pkg.
interface pgpm_out_if;
  logic                          valid;
  logic                          ready;
  logic [pgpm_pkg::PPM_W-1:0]    ppm_value;
  logic                          sensor_power;
  logic [pgpm_pkg::FAULT_W-1:0]  fault_level;

  modport source (output valid, output ppm_value, output sensor_power,
                  output fault_level, input ready);
  modport sink   (input valid, input ppm_value, input sensor_power,
                  input fault_level, output ready);
endinterface

// ===== src/pgpm_cfg_regs.sv =====
// Configuration register file of the ppm meter, written through a plain
// write port. Depends on pgpm_pkg.
module pgpm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [pgpm_pkg::IDX_W-1:0]   reg_index,
  input  logic [pgpm_pkg::DATA_W-1:0]  write_data,
  output pgpm_pkg::cfg_t               cfg
);

  // Load reset values, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_last_tick    <= 11'd1003;
      cfg.count_offset        <= 8'd2;
      cfg.ppm_per_count       <= 4'd5;
      cfg.ppm_floor           <= 16'd300;
      cfg.fault_stop_count    <= 8'd11;
      cfg.fault_restart_count <= 8'd21;
    end else if (write_enable) begin
      case (reg_index)
        pgpm_pkg::REG_WINDOW_LAST:   cfg.window_last_tick    <= write_data[10:0];
        pgpm_pkg::REG_COUNT_OFFSET:  cfg.count_offset        <= write_data[7:0];
        pgpm_pkg::REG_PPM_PER_COUNT: cfg.ppm_per_count       <= write_data[3:0];
        pgpm_pkg::REG_PPM_FLOOR:     cfg.ppm_floor           <= write_data[15:0];
        pgpm_pkg::REG_FAULT_STOP:    cfg.fault_stop_count    <= write_data[7:0];
        pgpm_pkg::REG_FAULT_RESTART: cfg.fault_restart_count <= write_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/pwm_gas_sensor_ppm_meter.sv =====
// Top level of the PWM gas sensor ppm meter: input register, state update
// and result register. Depends on pgpm_pkg, pgpm_in_if, pgpm_out_if and
// pgpm_cfg_regs.
//
//   port          dir   handshake       payload
//   items         sink  valid/ready     operation, pin_level
//   results       src   valid/ready     ppm_value, sensor_power, fault_level
//   write_enable  in    none            reg_index, write_data
//
// One beat per cycle sustained while results is not stalled. A beat is held in
// the input register, where the state update and the scaling multiply are
// done, and then leaves from the result register. Reset is synchronous and
// clears the state and the valid bits. A stall on results holds the result
// register, and a full input register holds and drops ready on items.
module pwm_gas_sensor_ppm_meter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [pgpm_pkg::IDX_W-1:0]   reg_index,
  input  logic [pgpm_pkg::DATA_W-1:0]  write_data,
  pgpm_in_if.sink                      items,
  pgpm_out_if.source                   results
);

  localparam int CB = pgpm_pkg::COUNT_BITS;
  localparam int TW = pgpm_pkg::TICK_W;
  localparam int PW = pgpm_pkg::PROD_W;

  pgpm_pkg::cfg_t cfg;

  pgpm_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  // Input register
  logic          in_vld;
  pgpm_pkg::op_t in_op;
  logic          in_pin;

  // Meter state
  logic [CB-1:0]                window_ticks, window_ticks_next;
  logic [CB-1:0]                high_samples, high_samples_next;
  logic [pgpm_pkg::PPM_W-1:0]   ppm_reading, ppm_reading_next;
  logic [pgpm_pkg::FAULT_W-1:0] fault_run, fault_run_next;
  logic                         running, running_next;

  // Result register
  logic                         out_vld;
  logic [pgpm_pkg::PPM_W-1:0]   out_ppm;
  logic                         out_power;
  logic [pgpm_pkg::FAULT_W-1:0] out_fault;

  logic advance;
  assign advance     = in_vld && (!out_vld || results.ready);
  assign items.ready = !in_vld || advance;

  // Tick datapath
  logic [TW-1:0]                tick_inc;
  logic [CB-1:0]                high_inc;
  logic                         window_close;
  logic [CB-1:0]                high_net;
  logic [PW-1:0]                prod;
  logic [pgpm_pkg::PPM_W-1:0]   ppm_new;
  logic [pgpm_pkg::FAULT_W-1:0] fault_inc;

  always_comb begin
    tick_inc = {1'b0, window_ticks} + TW'(1);
    high_inc = (in_pin && (high_samples != pgpm_pkg::CNT_MAX))
               ? high_samples + CB'(1) : high_samples;
    window_close = (tick_inc > TW'(cfg.window_last_tick)) || tick_inc[CB];
    // Clamp to zero at or below offset, saturate above 16 bits
    if (high_inc > CB'(cfg.count_offset)) high_net = high_inc - CB'(cfg.count_offset);
    else high_net = '0;
    prod = PW'(high_net) * PW'(cfg.ppm_per_count);
    if (32'(prod) > 32'h0000_FFFF) ppm_new = '1;
    else ppm_new = pgpm_pkg::PPM_W'(prod);
    fault_inc = (fault_run != '1) ? fault_run + pgpm_pkg::FAULT_W'(1) : fault_run;
  end

  // Next state for the beat in the input register
  always_comb begin
    window_ticks_next = window_ticks;
    high_samples_next = high_samples;
    ppm_reading_next  = ppm_reading;
    fault_run_next    = fault_run;
    running_next      = running;
    case (in_op)
      pgpm_pkg::OP_TICK: begin
        if (running) begin
          if (window_close) begin
            ppm_reading_next  = ppm_new;
            window_ticks_next = '0;
            high_samples_next = '0;
          end else begin
            window_ticks_next = tick_inc[CB-1:0];
            high_samples_next = high_inc;
          end
        end
      end
      pgpm_pkg::OP_READ: begin
        if (ppm_reading < cfg.ppm_floor) begin
          fault_run_next = fault_inc;
          if (fault_inc == cfg.fault_stop_count) begin
            running_next     = 1'b0;
            ppm_reading_next = '0;
          end else if (fault_inc >= cfg.fault_restart_count) begin
            running_next      = 1'b1;
            window_ticks_next = '0;
            high_samples_next = '0;
            ppm_reading_next  = '0;
            fault_run_next    = '0;
          end
        end else begin
          fault_run_next = '0;
        end
      end
      pgpm_pkg::OP_START: begin
        running_next      = 1'b1;
        window_ticks_next = '0;
        high_samples_next = '0;
        ppm_reading_next  = '0;
        fault_run_next    = '0;
      end
      default: begin
        running_next     = 1'b0;
        ppm_reading_next = '0;
      end
    endcase
  end

  // Capture beats, update state, load results
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld       <= 1'b0;
      out_vld      <= 1'b0;
      window_ticks <= '0;
      high_samples <= '0;
      ppm_reading  <= '0;
      fault_run    <= '0;
      running      <= 1'b0;
    end else begin
      if (items.valid && items.ready) begin
        in_vld <= 1'b1;
        in_op  <= items.operation;
        in_pin <= items.pin_level;
      end else if (advance) begin
        in_vld <= 1'b0;
      end

      if (advance) begin
        window_ticks <= window_ticks_next;
        high_samples <= high_samples_next;
        ppm_reading  <= ppm_reading_next;
        fault_run    <= fault_run_next;
        running      <= running_next;
        out_vld      <= 1'b1;
        out_ppm      <= ppm_reading_next;
        out_power    <= running_next;
        out_fault    <= fault_run_next;
      end else if (results.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign results.valid        = out_vld;
  assign results.ppm_value    = out_ppm;
  assign results.sensor_power = out_power;
  assign results.fault_level  = out_fault;

endmodule
